// ===== rtl/ftsf_pkg.sv =====
// shared types and constants for the five-tap smoothing filter
package ftsf_pkg;

    localparam int SAMPLE_BITS = 16;

    // kernel weights, (7,26,41,26,7) over 107
    localparam int W_OUTER  = 7;
    localparam int W_INNER  = 26;
    localparam int W_CENTER = 41;
    localparam int W_TOTAL  = 107;
    localparam int W_HALF   = W_TOTAL / 2;

    localparam int HIST_DEPTH = 4;
    localparam int COUNT_W    = 3;

    // weighted sum is at most 107 * 2^(SAMPLE_BITS-1) in magnitude
    localparam int ACC_W   = SAMPLE_BITS + 8;
    localparam int MAG_W   = SAMPLE_BITS + 7;
    localparam int QUOT_W  = MAG_W - 6;
    localparam int PROD_W  = MAG_W + QUOT_W;

    // floor(2^MAG_W / 107): quotient estimate is exact or one low
    localparam longint unsigned RECIP_L = (64'd1 << MAG_W) / W_TOTAL;
    localparam logic [QUOT_W-1:0] RECIP = QUOT_W'(RECIP_L);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          is_last;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] smoothed;
        logic                          final_out;
    } t_out_item;

endpackage

// ===== rtl/five_tap_smoothing_filter_top.sv =====
// five-tap smoothing filter: window push, weighted sum, divide by 107, result register
//
// Streams signed samples and returns the (7,26,41,26,7)/107 weighted average at each
// position, rounded to nearest with ties away from zero; the edge sample is repeated
// past both ends of a sequence. Results trail the input by two samples, and the request
// flagged is_last flushes the remaining positions, the final one marked by final_out.
// One request is taken per cycle while the output side accepts; a request with is_last
// set holds the input while the two flush pushes go through the window.
// Each push passes two register stages (weighted sum, reciprocal multiply) and then the
// quotient correction into the output register.
module five_tap_smoothing_filter_top
    import ftsf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    logic signed [SAMPLE_BITS-1:0] r_hist [HIST_DEPTH];
    logic [COUNT_W-1:0]            r_count;
    logic [1:0]                    r_flush_cnt;
    logic signed [SAMPLE_BITS-1:0] r_flush_sample;
    logic                          r_flush_first;

    logic                          r_v1;
    logic                          r_fin1;
    logic signed [ACC_W-1:0]       r_acc;

    logic                          r_v2;
    logic                          r_fin2;
    logic                          r_neg2;
    logic [MAG_W-1:0]              r_mag2;
    logic [PROD_W-1:0]             r_prod2;

    logic                          r_v3;
    t_out_item                     r_out;

    logic                          adv;
    logic                          take;
    logic                          push_en;
    logic                          push_valid;
    logic                          push_final;
    logic signed [SAMPLE_BITS-1:0] v;
    logic signed [SAMPLE_BITS-1:0] win [HIST_DEPTH+1];
    logic signed [ACC_W-1:0]       n_acc;
    logic signed [ACC_W-1:0]       acc_abs;
    logic [MAG_W-1:0]              n_mag;
    logic [QUOT_W-1:0]             q0;
    logic [MAG_W:0]                rem;
    logic [QUOT_W:0]               q;
    logic [SAMPLE_BITS-1:0]        q_s;
    t_out_item                     n_out;

    // whole pipe moves unless the output register is full and stalled
    assign adv        = !r_v3 || i_out_ready;
    assign o_in_ready = adv && (r_flush_cnt == 2'd0);
    assign take       = i_in_valid && o_in_ready;
    assign push_en    = take || (adv && (r_flush_cnt != 2'd0));
    assign v          = take ? i_in.sample : r_flush_sample;

    always_comb begin
        // first sample of a sequence fills the left edge
        for (int k = 0; k < HIST_DEPTH; k++) begin
            win[k] = (take && (r_count == '0)) ? v : r_hist[k];
        end
        win[HIST_DEPTH] = v;
    end

    always_comb begin
        if (take) begin
            push_valid = (r_count >= COUNT_W'(2));
            push_final = 1'b0;
        end else begin
            // flush pushes: the first one is centered on the item before the last
            push_valid = (r_flush_cnt == 2'd2) ? !r_flush_first : 1'b1;
            push_final = (r_flush_cnt == 2'd1);
        end
    end

    assign n_acc = ACC_W'(W_OUTER)  * (ACC_W'(win[0]) + ACC_W'(win[4]))
                 + ACC_W'(W_INNER)  * (ACC_W'(win[1]) + ACC_W'(win[3]))
                 + ACC_W'(W_CENTER) * ACC_W'(win[2]);

    assign acc_abs = r_acc[ACC_W-1] ? -r_acc : r_acc;
    assign n_mag   = MAG_W'(acc_abs) + MAG_W'(W_HALF);

    // quotient estimate is exact or one low, one compare fixes it
    assign q0  = r_prod2[PROD_W-1:MAG_W];
    assign rem = {1'b0, r_mag2} - (MAG_W+1)'(q0) * (MAG_W+1)'(W_TOTAL);
    assign q   = {1'b0, q0} + ((rem >= (MAG_W+1)'(W_TOTAL)) ? (QUOT_W+1)'(1) : '0);
    assign q_s = SAMPLE_BITS'(q);

    always_comb begin
        n_out.smoothed  = r_neg2 ? -q_s : q_s;
        n_out.final_out = r_fin2;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_flush_cnt <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
        end else begin
            if (take) begin
                if (i_in.is_last) begin
                    r_count     <= '0;
                    r_flush_cnt <= 2'd2;
                end else if (r_count != '1) begin
                    r_count <= r_count + COUNT_W'(1);
                end
            end else if (push_en) begin
                r_flush_cnt <= r_flush_cnt - 2'd1;
            end
            if (adv) begin
                r_v1 <= push_en && push_valid;
                r_v2 <= r_v1;
                r_v3 <= r_v2;
            end
        end
    end

    // window history and datapath
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            for (int k = 0; k < HIST_DEPTH - 1; k++) begin
                r_hist[k] <= win[k+1];
            end
            r_hist[HIST_DEPTH-1] <= v;
        end
        if (take) begin
            r_flush_sample <= i_in.sample;
            r_flush_first  <= (r_count == '0);
        end
        if (adv) begin
            r_acc   <= n_acc;
            r_fin1  <= push_final;
            r_fin2  <= r_fin1;
            r_neg2  <= r_acc[ACC_W-1];
            r_mag2  <= n_mag;
            r_prod2 <= PROD_W'(n_mag) * PROD_W'(RECIP);
            r_out   <= n_out;
        end
    end

    assign o_out_valid = r_v3;
    assign o_out       = r_out;

endmodule
